>>> hw/rtl/assert_macros.svh
// assertion macros used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	`ASSERT_PROP(lbl, clk, rstn, !(cond))

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> hw/rtl/ffe_pkg.sv
// shared constants, codes, control struct and helpers of the fall feature extractor
package ffe_pkg;

	localparam int WINDOW_DEF = 64;
	localparam int REAR_DEF   = 16;
	localparam int TRACE_DEF  = 20;

	localparam int SW     = 16;
	localparam int FW     = 15;
	localparam int GAP_W  = 7;

	localparam logic [FW-1:0] SAT_MAX = 15'h7fff;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PRIME = 3'd1;
	localparam logic [2:0] PH_SCAN  = 3'd2;
	localparam logic [2:0] PH_WALK  = 3'd3;
	localparam logic [2:0] PH_REAR  = 3'd4;
	localparam logic [2:0] PH_DIV   = 3'd5;
	localparam logic [2:0] PH_OUT   = 3'd6;

	localparam logic OP_PRIME  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic CFG_GRAVITY   = 1'b0;
	localparam logic CFG_GYRO_REST = 1'b1;

	typedef struct packed {
		logic scan_init;
		logic scan_vld;
		logic walk_init;
		logic walk_vld;
		logic walk_end;
		logic rear_init;
		logic rear_vld;
		logic div_load;
		logic out_load;
	} dp_ctl_t;

	function automatic logic [FW-1:0] sat_abs17(input logic signed [16:0] v);
		logic [16:0] m;
		m = v[16] ? 17'(-v) : 17'(v);
		return (m > 17'(SAT_MAX)) ? SAT_MAX : m[FW-1:0];
	endfunction

endpackage

>>> hw/rtl/ffe_ram.sv
// generic single write port ram with registered read
module ffe_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/ffe_seq.sv
// sequencer: phase control, window addressing and read tagging
`include "assert_macros.svh"

module ffe_seq #(
	parameter int WINDOW = ffe_pkg::WINDOW_DEF,
	parameter int REAR   = ffe_pkg::REAR_DEF,
	parameter int TRACE  = ffe_pkg::TRACE_DEF,
	localparam int AW = $clog2(WINDOW)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             start_op,
	input  logic             out_free,
	input  logic [AW-1:0]    a_pos,
	output logic             idle,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [AW-1:0]    rd_addr,
	output logic [AW-1:0]    newest,
	output logic [AW-1:0]    pos_s1,
	output logic [AW-1:0]    vis_s1,
	output ffe_pkg::dp_ctl_t ctl
);
	import ffe_pkg::*;

	localparam int BACK   = (WINDOW - REAR > 0) ? WINDOW - REAR : 0;
	localparam int N_SCAN = (WINDOW - REAR - 1 > 0) ? WINDOW - REAR - 1 : 0;
	localparam int M1     = (WINDOW > TRACE + 1) ? WINDOW : TRACE + 1;
	localparam int M2     = (M1 > REAR) ? M1 : REAR;
	localparam int CMAX   = M2;
	localparam int CW     = $clog2(CMAX + 1);

	logic [2:0]    phase_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] newest_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] newest_nxt;
	logic [AW-1:0] scan_start;
	logic [AW:0]   start_sum;
	logic          rd_en;
	logic          scan_s1_q;
	logic          walk_s1_q;
	logic          wend_s1_q;
	logic          rear_s1_q;

	// first scanned entry sits WINDOW-REAR places behind the newest one
	assign start_sum  = {1'b0, newest_q} + (AW + 1)'(WINDOW - BACK);
	assign scan_start = (start_sum >= (AW + 1)'(WINDOW)) ?
		AW'(start_sum - (AW + 1)'(WINDOW)) : start_sum[AW-1:0];
	assign newest_nxt = (newest_q == AW'(WINDOW - 1)) ? '0 : newest_q + 1'b1;

	always_comb begin
		case (phase_q)
			PH_SCAN: begin
				rd_addr = (cnt_q == '0) ? scan_start : addr_q;
				rd_en   = cnt_q < CW'(N_SCAN);
			end
			PH_WALK: begin
				rd_addr = (cnt_q == '0) ? a_pos : addr_q;
				rd_en   = cnt_q <= CW'(TRACE);
			end
			PH_REAR: begin
				rd_addr = (cnt_q == '0) ? newest_q : addr_q;
				rd_en   = cnt_q < CW'(REAR - 1);
			end
			default: begin
				rd_addr = addr_q;
				rd_en   = 1'b0;
			end
		endcase
	end

	assign idle    = phase_q == PH_IDLE;
	assign newest  = newest_q;
	assign wr_en   = (start && start_op == OP_SAMPLE) || phase_q == PH_PRIME;
	assign wr_addr = (phase_q == PH_PRIME) ? cnt_q[AW-1:0] : newest_nxt;

	always_comb begin
		ctl.scan_init = phase_q == PH_SCAN && cnt_q == '0;
		ctl.scan_vld  = scan_s1_q;
		ctl.walk_init = phase_q == PH_WALK && cnt_q == '0;
		ctl.walk_vld  = walk_s1_q;
		ctl.walk_end  = wend_s1_q;
		ctl.rear_init = phase_q == PH_REAR && cnt_q == '0;
		ctl.rear_vld  = rear_s1_q;
		ctl.div_load  = phase_q == PH_DIV;
		ctl.out_load  = phase_q == PH_OUT && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			newest_q  <= AW'(WINDOW - 1);
			scan_s1_q <= 1'b0;
			walk_s1_q <= 1'b0;
			wend_s1_q <= 1'b0;
			rear_s1_q <= 1'b0;
		end else begin
			scan_s1_q <= phase_q == PH_SCAN && rd_en;
			walk_s1_q <= phase_q == PH_WALK && rd_en && cnt_q < CW'(TRACE);
			wend_s1_q <= phase_q == PH_WALK && rd_en && cnt_q == CW'(TRACE);
			rear_s1_q <= phase_q == PH_REAR && rd_en;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (start_op == OP_PRIME) begin
							phase_q <= PH_PRIME;
						end else begin
							phase_q  <= PH_SCAN;
							newest_q <= newest_nxt;
						end
					end
				end
				PH_PRIME: begin
					if (cnt_q == CW'(WINDOW - 1)) begin
						phase_q  <= PH_IDLE;
						cnt_q    <= '0;
						newest_q <= AW'(WINDOW - 1);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_SCAN: begin
					if (cnt_q == CW'(N_SCAN)) begin
						phase_q <= PH_WALK;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_WALK: begin
					// one extra read fetches x at the stop position
					if (cnt_q == CW'(TRACE + 1)) begin
						phase_q <= PH_REAR;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_REAR: begin
					if (cnt_q == CW'(REAR - 1)) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DIV: begin
					phase_q <= PH_OUT;
					cnt_q   <= '0;
				end
				PH_OUT: begin
					if (out_free) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q <= (rd_addr == '0) ? AW'(WINDOW - 1) : rd_addr - 1'b1;
			pos_s1 <= rd_addr;
			vis_s1 <= AW'(cnt_q + 1'b1);
		end
	end

	`ASSERT_PROP(a_prime_entry, clk, arst_n, (start && start_op == OP_PRIME) |=> phase_q == PH_PRIME)
	`ASSERT_NEVER(a_newest_range, clk, arst_n, newest_q > AW'(WINDOW - 1))
	`ASSERT_PROP(a_out_return, clk, arst_n, (phase_q == PH_OUT && out_free) |=> phase_q == PH_IDLE)
	`ASSERT_NEVER(a_start_busy, clk, arst_n, start && phase_q != PH_IDLE)

endmodule

>>> hw/rtl/ffe_dp.sv
// datapath: peak search, backward walk sums, rear sum and reciprocal divide
module ffe_dp #(
	parameter int WINDOW = ffe_pkg::WINDOW_DEF,
	parameter int REAR   = ffe_pkg::REAR_DEF,
	parameter int TRACE  = ffe_pkg::TRACE_DEF,
	localparam int AW = $clog2(WINDOW)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ffe_pkg::dp_ctl_t                   ctl,
	input  logic [AW-1:0]                      pos,
	input  logic [AW-1:0]                      vis,
	input  logic [AW-1:0]                      newest,
	input  logic signed [ffe_pkg::SW-1:0]      rd_x,
	input  logic signed [ffe_pkg::SW-1:0]      rd_mag,
	input  logic signed [ffe_pkg::SW-1:0]      rd_gyro,
	input  logic signed [ffe_pkg::SW-1:0]      x_new,
	input  logic signed [ffe_pkg::SW-1:0]      mag_new,
	input  logic signed [ffe_pkg::SW-1:0]      gravity,
	input  logic signed [ffe_pkg::SW-1:0]      gyro_rest,
	output logic [AW-1:0]                      a_pos,
	output logic signed [ffe_pkg::SW-1:0]      accel_peak,
	output logic [ffe_pkg::FW-1:0]             drop_speed,
	output logic signed [ffe_pkg::SW-1:0]      gyro_peak,
	output logic [ffe_pkg::FW-1:0]             tilt_sum,
	output logic [ffe_pkg::GAP_W-1:0]          peak_gap,
	output logic [ffe_pkg::FW-1:0]             end_accel_x,
	output logic [ffe_pkg::FW-1:0]             rest_deviation,
	output logic [ffe_pkg::FW-1:0]             rest_mean_x
);
	import ffe_pkg::*;

	localparam int MAG_W  = $clog2(REAR) + SW;
	localparam int SUM_W  = MAG_W + 1;
	localparam int LD     = $clog2(REAR);
	localparam int SH     = MAG_W + LD;
	localparam int PROD_W = 2 * MAG_W + 2;
	// rounded-up reciprocal, exact quotient for every magnitude below 2**MAG_W
	localparam logic [MAG_W+1:0] RECIP =
		(MAG_W + 2)'(((longint'(1) << SH) + longint'(REAR) - 1) / longint'(REAR));

	logic signed [SW-1:0]    a_peak_q;
	logic signed [SW-1:0]    g_peak_q;
	logic [AW-1:0]           a_vis_q;
	logic [AW-1:0]           g_vis_q;
	logic [AW-1:0]           a_pos_q;
	logic [FW-1:0]           vel_q;
	logic [FW-1:0]           ang_q;
	logic                    stop_q;
	logic [FW-1:0]           end_x_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [FW-1:0]           quo_q;
	logic signed [16:0]      deficit;
	logic signed [16:0]      excess;
	logic [17:0]             vel_sum;
	logic [17:0]             ang_sum;
	logic [MAG_W-1:0]        sum_mag;
	logic [PROD_W-1:0]       prod;
	logic [AW-1:0]           vis_diff;

	assign deficit = {gravity[SW-1], gravity} - {rd_mag[SW-1], rd_mag};
	assign excess  = {rd_gyro[SW-1], rd_gyro} - {gyro_rest[SW-1], gyro_rest};
	assign vel_sum = {3'b0, vel_q} + {1'b0, deficit};
	assign ang_sum = {3'b0, ang_q} + {1'b0, excess};
	assign sum_mag = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
	assign prod    = PROD_W'(sum_mag) * PROD_W'(RECIP);
	assign vis_diff = (a_vis_q > g_vis_q) ? a_vis_q - g_vis_q : g_vis_q - a_vis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
		end else if (ctl.walk_init) begin
			stop_q <= 1'b0;
		end else if (ctl.walk_vld && pos == newest) begin
			stop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_init) begin
			a_peak_q <= {1'b1, {(SW - 1){1'b0}}};
			g_peak_q <= {1'b1, {(SW - 1){1'b0}}};
			a_vis_q  <= '0;
			g_vis_q  <= '0;
			a_pos_q  <= '0;
		end else if (ctl.scan_vld) begin
			if (rd_mag > a_peak_q) begin
				a_peak_q <= rd_mag;
				a_vis_q  <= vis;
				a_pos_q  <= pos;
			end
			if (rd_gyro > g_peak_q) begin
				g_peak_q <= rd_gyro;
				g_vis_q  <= vis;
			end
		end

		if (ctl.walk_init) begin
			vel_q <= '0;
			ang_q <= '0;
		end else if (ctl.walk_vld && !stop_q) begin
			if (rd_mag < gravity) begin
				vel_q <= (vel_sum > 18'(SAT_MAX)) ? SAT_MAX : vel_sum[FW-1:0];
			end
			if (rd_gyro >= gyro_rest) begin
				ang_q <= (ang_sum > 18'(SAT_MAX)) ? SAT_MAX : ang_sum[FW-1:0];
			end
		end

		// an early stop leaves the walk on the newest entry
		if (ctl.walk_end) begin
			end_x_q <= stop_q ? sat_abs17({x_new[SW-1], x_new}) :
				sat_abs17({rd_x[SW-1], rd_x});
		end

		if (ctl.rear_init) begin
			sum_q <= '0;
		end else if (ctl.rear_vld) begin
			sum_q <= sum_q + SUM_W'(rd_x);
		end

		// divide of the magnitude by the rear length
		if (ctl.div_load) begin
			quo_q <= prod[SH+FW-1:SH];
		end
	end

	assign a_pos          = a_pos_q;
	assign accel_peak     = a_peak_q;
	assign gyro_peak      = g_peak_q;
	assign drop_speed     = vel_q;
	assign tilt_sum       = ang_q;
	assign peak_gap       = GAP_W'(vis_diff);
	assign end_accel_x    = end_x_q;
	assign rest_deviation = sat_abs17({mag_new[SW-1], mag_new} - {gravity[SW-1], gravity});
	assign rest_mean_x    = quo_q;

endmodule

>>> hw/rtl/fall_feature_extractor.sv
// fall feature extractor top level: stream ports, config registers, window ram, output register
//
// Input beats on s_* carry one sample (x, magnitude, gyro) and a kind in s_tuser:
// prime fills every window entry with the sample and gives no result, a normal
// sample is stored as the newest entry and gives one result beat on m_*.
// Config writes on cfg_* set gravity level (index 0) and gyro rest level
// (index 1); cfg_ready is always high and writes belong to idle periods.
// A normal sample goes from accept to result load through peak scan, backward
// walk, rear sum, reciprocal divide and output load, all through the one read
// port of the window ram. A prime fills the window with one ram write per cycle.
// s_tready is high only while idle, so a new sample is accepted only once the
// block has loaded the result of the previous one into the output register.
// The result sits in an output register; a stalled receiver holds the block
// in its final step until the register frees, while the register itself lets
// the next sample be accepted as soon as the result is loaded.
// Reset clears the sequencer and output valid and sets the config defaults;
// window contents stay undefined until the first prime.
module fall_feature_extractor #(
	parameter int WINDOW = ffe_pkg::WINDOW_DEF,
	parameter int REAR   = ffe_pkg::REAR_DEF,
	parameter int TRACE  = ffe_pkg::TRACE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // accel_x, accel_mag, gyro_mag
	input  logic [0:0]   s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // accel_peak, drop_speed, gyro_peak, tilt_sum,
	                                // peak_gap, end_accel_x, rest_deviation, rest_mean_x
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import ffe_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam int RW = 3 * SW;

	logic                 s_accept;
	logic                 idle;
	logic                 out_free;
	logic                 m_tvalid_q;
	logic [119:0]         m_tdata_q;
	logic signed [SW-1:0] gravity_q;
	logic signed [SW-1:0] gyro_rest_q;
	logic [RW-1:0]        sample_q;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [RW-1:0]        wr_data;
	logic [AW-1:0]        rd_addr;
	logic [RW-1:0]        rd_data;
	logic [AW-1:0]        newest;
	logic [AW-1:0]        pos_s1;
	logic [AW-1:0]        vis_s1;
	logic [AW-1:0]        a_pos;
	dp_ctl_t              ctl;
	logic signed [SW-1:0] accel_peak;
	logic [FW-1:0]        drop_speed;
	logic signed [SW-1:0] gyro_peak;
	logic [FW-1:0]        tilt_sum;
	logic [GAP_W-1:0]     peak_gap;
	logic [FW-1:0]        end_accel_x;
	logic [FW-1:0]        rest_deviation;
	logic [FW-1:0]        rest_mean_x;

	assign s_tready  = idle;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q   <= 16'sd1024;
			gyro_rest_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRAVITY:   gravity_q   <= cfg_data;
				CFG_GYRO_REST: gyro_rest_q <= cfg_data;
				default:       gravity_q   <= gravity_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			sample_q <= s_tdata;
		end
	end

	// a normal sample is written on its accept beat, prime writes replay it
	assign wr_data = s_accept ? s_tdata : sample_q;

	ffe_ram #(
		.WIDTH(RW),
		.DEPTH(WINDOW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ffe_seq #(
		.WINDOW(WINDOW),
		.REAR  (REAR),
		.TRACE (TRACE)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_accept),
		.start_op(s_tuser[0]),
		.out_free(out_free),
		.a_pos   (a_pos),
		.idle    (idle),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.newest  (newest),
		.pos_s1  (pos_s1),
		.vis_s1  (vis_s1),
		.ctl     (ctl)
	);

	ffe_dp #(
		.WINDOW(WINDOW),
		.REAR  (REAR),
		.TRACE (TRACE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.pos           (pos_s1),
		.vis           (vis_s1),
		.newest        (newest),
		.rd_x          (rd_data[SW-1:0]),
		.rd_mag        (rd_data[2*SW-1:SW]),
		.rd_gyro       (rd_data[3*SW-1:2*SW]),
		.x_new         (sample_q[SW-1:0]),
		.mag_new       (sample_q[2*SW-1:SW]),
		.gravity       (gravity_q),
		.gyro_rest     (gyro_rest_q),
		.a_pos         (a_pos),
		.accel_peak    (accel_peak),
		.drop_speed    (drop_speed),
		.gyro_peak     (gyro_peak),
		.tilt_sum      (tilt_sum),
		.peak_gap      (peak_gap),
		.end_accel_x   (end_accel_x),
		.rest_deviation(rest_deviation),
		.rest_mean_x   (rest_mean_x)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			m_tdata_q <= {6'd0, rest_mean_x, rest_deviation, end_accel_x, peak_gap,
				tilt_sum, gyro_peak, drop_speed, accel_peak};
		end
	end

endmodule

>>> verif/ffe_checker.sv
`timescale 1ns / 100ps
// checker for the fall feature extractor: tracks windows and config, predicts and compares results
module ffe_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [47:0]  s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [119:0] m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           fail_count,
	output int           waiting,
	output int           result_count
);
	import ffe_pkg::*;

	localparam int W = WINDOW_DEF;
	localparam int R = REAR_DEF;
	localparam int T = TRACE_DEF;

	// highest field first, so accel_peak lands in the lowest bits
	typedef struct packed {
		logic [14:0]        rest_mean_x;
		logic [14:0]        rest_deviation;
		logic [14:0]        end_accel_x;
		logic [6:0]         peak_gap;
		logic [14:0]        tilt_sum;
		logic signed [15:0] gyro_peak;
		logic [14:0]        drop_speed;
		logic signed [15:0] accel_peak;
	} features_t;

	logic signed [15:0] x_win [W];
	logic signed [15:0] mag_win [W];
	logic signed [15:0] gyro_win [W];
	int                 newest;
	int                 gravity;
	int                 gyro_rest;
	features_t          expected_features [$];

	function automatic int step_back(input int p);
		return (p == 0) ? W - 1 : p - 1;
	endfunction

	function automatic logic [14:0] clip_abs(input int v);
		if (v < 0) v = -v;
		return (v > 32767) ? 15'h7fff : v[14:0];
	endfunction

	function automatic features_t compute_features();
		features_t f;
		int pos, a_peak, g_peak, a_vis, g_vis, a_pos, vel, ang, gap, sum_x, p;
		a_peak = -32768;
		g_peak = -32768;
		a_vis = 0;
		g_vis = 0;
		a_pos = 0;
		vel = 0;
		ang = 0;
		sum_x = 0;
		pos = newest;
		for (int i = 0; i < W - R; i++) pos = step_back(pos);
		for (int i = 1; i < W - R; i++) begin
			if (int'(mag_win[pos]) > a_peak) begin
				a_peak = mag_win[pos];
				a_pos = pos;
				a_vis = i;
			end
			if (int'(gyro_win[pos]) > g_peak) begin
				g_peak = gyro_win[pos];
				g_vis = i;
			end
			pos = step_back(pos);
		end
		// backward walk from the accel peak, stops after the newest entry
		pos = a_pos;
		for (int i = 0; i < T; i++) begin
			if (int'(mag_win[pos]) < gravity) begin
				vel += gravity - int'(mag_win[pos]);
				if (vel > 32767) vel = 32767;
			end
			if (int'(gyro_win[pos]) >= gyro_rest) begin
				ang += int'(gyro_win[pos]) - gyro_rest;
				if (ang > 32767) ang = 32767;
			end
			if (pos == newest) break;
			pos = step_back(pos);
		end
		gap = g_vis - a_vis;
		if (gap < 0) gap = -gap;
		p = newest;
		for (int i = 1; i < R; i++) begin
			sum_x += x_win[p];
			p = step_back(p);
		end
		f.accel_peak     = a_peak[15:0];
		f.drop_speed     = vel[14:0];
		f.gyro_peak      = g_peak[15:0];
		f.tilt_sum       = ang[14:0];
		f.peak_gap       = gap[6:0];
		f.end_accel_x    = clip_abs(x_win[pos]);
		f.rest_deviation = clip_abs(int'(mag_win[newest]) - gravity);
		f.rest_mean_x    = clip_abs(sum_x / R);
		return f;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	assign waiting = expected_features.size();

	always @(posedge clk or negedge arst_n) begin
		features_t got, want;
		if (!arst_n) begin
			gravity = 1024;
			gyro_rest = 0;
			newest = W - 1;
			fail_count = 0;
			result_count = 0;
			expected_features.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = features_t'(m_tdata[113:0]);
				result_count++;
				if (expected_features.size() == 0) begin
					report_mismatch("result beats", result_count, result_count - 1);
				end else begin
					want = expected_features.pop_front();
					if (got.accel_peak != want.accel_peak)
						report_mismatch("accel_peak", got.accel_peak, want.accel_peak);
					if (got.drop_speed != want.drop_speed)
						report_mismatch("drop_speed", got.drop_speed, want.drop_speed);
					if (got.gyro_peak != want.gyro_peak)
						report_mismatch("gyro_peak", got.gyro_peak, want.gyro_peak);
					if (got.tilt_sum != want.tilt_sum)
						report_mismatch("tilt_sum", got.tilt_sum, want.tilt_sum);
					if (got.peak_gap != want.peak_gap)
						report_mismatch("peak_gap", got.peak_gap, want.peak_gap);
					if (got.end_accel_x != want.end_accel_x)
						report_mismatch("end_accel_x", got.end_accel_x, want.end_accel_x);
					if (got.rest_deviation != want.rest_deviation)
						report_mismatch("rest_deviation", got.rest_deviation,
							want.rest_deviation);
					if (got.rest_mean_x != want.rest_mean_x)
						report_mismatch("rest_mean_x", got.rest_mean_x, want.rest_mean_x);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GRAVITY) gravity = $signed(cfg_data);
				else gyro_rest = $signed(cfg_data);
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_PRIME) begin
					for (int i = 0; i < W; i++) begin
						x_win[i] = s_tdata[15:0];
						mag_win[i] = s_tdata[31:16];
						gyro_win[i] = s_tdata[47:32];
					end
					newest = W - 1;
				end else begin
					newest = (newest + 1) % W;
					x_win[newest] = s_tdata[15:0];
					mag_win[newest] = s_tdata[31:16];
					gyro_win[newest] = s_tdata[47:32];
					expected_features.push_back(compute_features());
				end
			end
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the fall feature extractor: stimulus, stall patterns, watchdog and verdict
module tb_top;
	import ffe_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;   // accel_x, accel_mag, gyro_mag
	logic [0:0]   s_tuser;   // op
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;   // accel_peak, drop_speed, gyro_peak, tilt_sum,
	                         // peak_gap, end_accel_x, rest_deviation, rest_mean_x
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_data;

	int fail_count, waiting, result_count;
	int send_idle_pct, recv_idle_pct;
	int sample_count, prime_count, quiet_cycles;

	fall_feature_extractor u_top (.*);

	ffe_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", waiting);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [15:0] pick_value(input int centre);
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'($urandom);
			default: return 16'(centre + int'($urandom_range(1200)) - 600);
		endcase
	endfunction

	task automatic send_beat(input logic op, input logic [15:0] ax, input logic [15:0] am,
			input logic [15:0] gm);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {gm, am, ax};
		do @(posedge clk); while (!s_tready);
		if (op == OP_PRIME) prime_count++;
		else sample_count++;
	endtask

	task automatic send_sample(input logic [15:0] ax, input logic [15:0] am,
			input logic [15:0] gm);
		send_beat(OP_SAMPLE, ax, am, gm);
	endtask

	// lets every result and a trailing prime finish
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting > 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count, input int grav);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 4)
				send_beat(OP_PRIME, pick_value(0), pick_value(grav), pick_value(0));
			else
				send_sample(pick_value(0), pick_value(grav), pick_value(0));
		end
	endtask

	initial begin
		int grav;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_PRIME;
		cfg_valid = 1'b0;
		cfg_index = CFG_GRAVITY;
		cfg_data = '0;
		send_idle_pct = 18;
		recv_idle_pct = 60;
		sample_count = 0;
		prime_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes with the reset levels
		send_beat(OP_PRIME, 16'h8000, 16'h7fff, 16'h8000);
		send_sample(16'h7fff, 16'h8000, 16'h7fff);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff);
		send_sample(16'h0000, 16'h0000, 16'h0000);
		// all entries at the floor: no peak update
		send_beat(OP_PRIME, 16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h8000, 16'h0400, 16'h0000);
		send_beat(OP_PRIME, 16'h0000, 16'h0400, 16'h0000);
		for (int n = 0; n < 5; n++) send_sample(16'h0100, 16'h0200, 16'h0300);
		drain();
		// extreme levels drive the sums and distances into saturation
		write_reg(CFG_GRAVITY, 16'h7fff);
		write_reg(CFG_GYRO_REST, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h7fff);
		send_sample(16'h7fff, 16'h8000, 16'h7fff);
		send_sample(16'h8000, 16'h7fff, 16'h8000);
		drain();
		write_reg(CFG_GRAVITY, 16'h8000);
		write_reg(CFG_GYRO_REST, 16'h7fff);
		send_sample(16'h8000, 16'h7fff, 16'h7fff);
		send_sample(16'h0000, 16'h8000, 16'h8000);
		drain();

		// random phases with three stall patterns and level settings
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: grav = 1024;
				1: grav = 4096;
				default: grav = $signed(16'($urandom));
			endcase
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 60 : 0;
			recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 18 : 0;
			write_reg(CFG_GRAVITY, 16'(grav));
			write_reg(CFG_GYRO_REST, (ph == 0) ? 16'h0000 : 16'($urandom_range(600)));
			send_beat(OP_PRIME, pick_value(0), pick_value(grav), pick_value(0));
			run_random(130, grav);
			drain();
		end

		$display("covered %0d samples and %0d primes with %0d results checked,",
			sample_count, prime_count, result_count);
		$display("under extreme and typical levels and three stall patterns");
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
